### hw/rtl/qsu_pkg.sv
// shared types, codes and helper functions for the quoted string unescaper
`default_nettype none
package qsu_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int MAX_RESULTS = 6;

  // one step of the byte offset
  localparam logic [OFFSET_BITS-1:0] OFFSET_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  // parser modes
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_OK     = 3'd1;
  localparam logic [2:0] ST_BADESC = 3'd2;
  localparam logic [2:0] ST_BADHEX = 3'd3;
  localparam logic [2:0] ST_UNTERM = 3'd4;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // utf-8 length thresholds and lead markers
  localparam logic [31:0] UTF_LIM2 = 32'h0000_0080;
  localparam logic [31:0] UTF_LIM3 = 32'h0000_0800;
  localparam logic [31:0] UTF_LIM4 = 32'h0001_0000;
  localparam logic [31:0] UTF_LIM5 = 32'h0020_0000;
  localparam logic [31:0] UTF_LIM6 = 32'h0400_0000;
  localparam logic [7:0]  LEAD2    = 8'hc0;
  localparam logic [7:0]  LEAD3    = 8'he0;
  localparam logic [7:0]  LEAD4    = 8'hf0;
  localparam logic [7:0]  LEAD5    = 8'hf8;
  localparam logic [7:0]  LEAD6    = 8'hfc;
  localparam logic [7:0]  CONT     = 8'h80;
  localparam logic [5:0]  SIX_MASK = 6'h3f;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [5:0][7:0] bytes;
  } utf_t;

  // group of results caused by one request, bytes[0] goes out first
  typedef struct packed {
    logic [2:0]      cnt;
    logic [5:0][7:0] bytes;
    logic [2:0]      status;
    logic [15:0]     pos;
  } grp_t;

  function automatic logic [15:0] pos_of(input logic [OFFSET_BITS-1:0] o);
    logic [31:0] w;
    w = 32'(o);
    return w[15:0];
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {["0":"9"]}) r = {1'b1, 4'(c - "0")};
    else if (c inside {["a":"f"]}) r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c inside {["A":"F"]}) r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  function automatic utf_t utf8_encode(input logic [31:0] v);
    utf_t        r;
    logic [35:0] w;
    logic [2:0]  n;
    logic [7:0]  lead;
    w = {4'b0000, v};
    if (v < UTF_LIM2) begin
      n = 3'd1; lead = v[7:0];
    end else if (v < UTF_LIM3) begin
      n = 3'd2; lead = LEAD2 | 8'(v >> 6);
    end else if (v < UTF_LIM4) begin
      n = 3'd3; lead = LEAD3 | 8'(v >> 12);
    end else if (v < UTF_LIM5) begin
      n = 3'd4; lead = LEAD4 | 8'(v >> 18);
    end else if (v < UTF_LIM6) begin
      n = 3'd5; lead = LEAD5 | 8'(v >> 24);
    end else begin
      n = 3'd6; lead = LEAD6 | 8'(v >> 30);
    end
    r.cnt = n;
    r.bytes = '0;
    r.bytes[0] = lead;
    for (int k = 1; k < MAX_RESULTS; k++) begin
      if (k < int'(n)) begin
        r.bytes[k] = CONT | {2'b00, w[6*(int'(n)-1-k) +: 6] & SIX_MASK};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/quoted_string_unescape.sv
// top level of the quoted string unescaper
// Usage:
//  s_* carries one request per handshake: s_tuser is the operation (0 string byte,
//  1 end of input buffer), s_tdata the raw byte. Feed the bytes that follow the
//  opening quote. m_* carries results: decoded byte and position in m_tdata,
//  status in m_tuser, m_tlast on the final result that a request causes.
//  The results of an accepted request are registered and show on m_* in the
//  next cycle. Throughput: one request per cycle while m_tready stays high and
//  each request gives at most one result; a final hex digit that expands to n
//  utf-8 bytes keeps s_tready low while the bytes play out of the result
//  register. Backslashes, escape letters u/U and inner hex digits give no
//  result and are taken back to back.
//  A closing quote, an error or an end-of-input request ends the string; the
//  next byte starts a new one at offset zero.
//  Reset: rst clears the parser to text mode at offset zero and drops m_tvalid.
//  Stall: while m_tready is low the pending result holds and s_tready stays
//  low for as long as a result waits in the result register.
`default_nettype none
module quoted_string_unescape (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tuser,   // [0] operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] position
  output logic [2:0]       m_tuser,   // [2:0] status
  output logic             m_tlast
);

  qsu_pkg::grp_t grp;
  logic          accept;
  logic          load;
  logic          take;
  logic [7:0]    out_byte;
  logic [15:0]   position;

  assign accept = s_tvalid && s_tready;
  assign load   = accept && (grp.cnt != 3'd0);
  assign take   = m_tvalid && m_tready;

  qsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (s_tuser),
    .in_byte   (s_tdata),
    .grp       (grp)
  );

  qsu_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp      (grp),
    .ready    (s_tready),
    .valid    (m_tvalid),
    .take     (take),
    .out_byte (out_byte),
    .status   (m_tuser),
    .position (position),
    .last     (m_tlast)
  );

  assign m_tdata = {position, out_byte};

endmodule
`default_nettype wire

### hw/rtl/qsu_decode.sv
// parser state and per-request decode into a result group
`default_nettype none
module qsu_decode (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic           operation,
  input  wire logic [7:0]     in_byte,
  output qsu_pkg::grp_t       grp
);

  logic [1:0]                       mode, mode_next;
  logic [31:0]                      code_value, code_value_next;
  logic [3:0]                       digits_left, digits_left_next;
  logic [2:0]                       digit_index, digit_index_next;
  logic [qsu_pkg::OFFSET_BITS-1:0]  offset, offset_next;

  logic [qsu_pkg::OFFSET_BITS-1:0]  here, nxt;
  logic [4:0]                       hex;
  logic [31:0]                      cv_shift;
  logic [3:0]                       dl_dec;
  qsu_pkg::utf_t                    utf;

  assign here     = offset;
  assign nxt      = offset + qsu_pkg::OFFSET_ONE;
  assign hex      = qsu_pkg::hex_decode(in_byte);
  assign cv_shift = {code_value[27:0], hex[3:0]};
  assign dl_dec   = digits_left - 4'd1;
  assign utf      = qsu_pkg::utf8_encode(cv_shift);

  always_comb begin
    mode_next        = mode;
    code_value_next  = code_value;
    digits_left_next = digits_left;
    digit_index_next = digit_index;
    offset_next      = offset;
    grp              = '0;
    grp.status       = qsu_pkg::ST_DATA;
    grp.pos          = qsu_pkg::pos_of(here);

    if (operation == qsu_pkg::OP_END) begin
      grp.cnt    = 3'd1;
      grp.status = qsu_pkg::ST_UNTERM;
      mode_next = qsu_pkg::MODE_TEXT; code_value_next = '0;
      digits_left_next = '0; digit_index_next = '0; offset_next = '0;
    end else begin
      case (mode)
        qsu_pkg::MODE_ESC: begin
          offset_next = nxt;
          mode_next   = qsu_pkg::MODE_TEXT;
          grp.cnt     = 3'd1;
          case (in_byte)
            "b":  grp.bytes[0] = 8'h08;
            "t":  grp.bytes[0] = 8'h09;
            "n":  grp.bytes[0] = 8'h0a;
            "f":  grp.bytes[0] = 8'h0c;
            "r":  grp.bytes[0] = 8'h0d;
            "\"": grp.bytes[0] = 8'h22;
            "/":  grp.bytes[0] = 8'h2f;
            "\\": grp.bytes[0] = 8'h5c;
            "u", "U": begin
              grp.cnt          = 3'd0;
              mode_next        = qsu_pkg::MODE_HEX;
              digits_left_next = (in_byte == "u") ? 4'd4 : 4'd8;
              code_value_next  = '0;
              digit_index_next = '0;
            end
            default: begin
              // bad escape reports the backslash position
              grp.status = qsu_pkg::ST_BADESC;
              grp.pos    = qsu_pkg::pos_of(here - qsu_pkg::OFFSET_ONE);
              code_value_next = '0; digits_left_next = '0;
              digit_index_next = '0; offset_next = '0;
            end
          endcase
        end
        qsu_pkg::MODE_HEX: begin
          if (!hex[4]) begin
            grp.cnt    = 3'd1;
            grp.status = qsu_pkg::ST_BADHEX;
            grp.pos    = 16'(digit_index);
            mode_next = qsu_pkg::MODE_TEXT; code_value_next = '0;
            digits_left_next = '0; digit_index_next = '0; offset_next = '0;
          end else begin
            code_value_next  = cv_shift;
            digit_index_next = digit_index + 3'd1;
            digits_left_next = dl_dec;
            offset_next      = nxt;
            if (dl_dec == 4'd0) begin
              grp.cnt          = utf.cnt;
              grp.bytes        = utf.bytes;
              mode_next        = qsu_pkg::MODE_TEXT;
              code_value_next  = '0;
              digit_index_next = '0;
            end
          end
        end
        default: begin
          if (in_byte == "\"") begin
            grp.cnt    = 3'd1;
            grp.status = qsu_pkg::ST_OK;
            grp.pos    = qsu_pkg::pos_of(nxt);
            mode_next = qsu_pkg::MODE_TEXT; code_value_next = '0;
            digits_left_next = '0; digit_index_next = '0; offset_next = '0;
          end else if (in_byte == "\\") begin
            mode_next   = qsu_pkg::MODE_ESC;
            offset_next = nxt;
          end else begin
            grp.cnt      = 3'd1;
            grp.bytes[0] = in_byte;
            offset_next  = nxt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= qsu_pkg::MODE_TEXT;
      code_value  <= '0;
      digits_left <= '0;
      digit_index <= '0;
      offset      <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      code_value  <= code_value_next;
      digits_left <= digits_left_next;
      digit_index <= digit_index_next;
      offset      <= offset_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/qsu_emit.sv
// result register that plays out a group of result bytes one per cycle while take is high
`default_nettype none
module qsu_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire qsu_pkg::grp_t  grp,
  output logic                ready,
  output logic                valid,
  input  wire logic           take,
  output logic [7:0]          out_byte,
  output logic [2:0]          status,
  output logic [15:0]         position,
  output logic                last
);

  logic [2:0]      cnt;
  logic [5:0][7:0] bytes;
  logic            done;

  assign out_byte = bytes[0];
  assign last     = (cnt == 3'd1);
  assign done     = take && last;
  assign ready    = !valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      cnt   <= grp.cnt;
    end else if (take) begin
      valid <= !done;
      cnt   <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= grp.bytes;
      status   <= grp.status;
      position <= grp.pos;
    end else if (take) begin
      bytes <= bytes >> 8;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (cnt != 3'd0 && 32'(cnt) <= qsu_pkg::MAX_RESULTS))
    else $error("result count out of range while valid");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("group loaded over one still playing out");

  a_load_cnt: assert property (@(posedge clk) disable iff (rst)
    load |=> (valid && cnt == $past(grp.cnt)))
    else $error("loaded group count lost");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (take && !last && !load) |=> (valid && cnt == 3'($past(cnt) - 3'd1)))
    else $error("partial group not advanced by one");

endmodule
`default_nettype wire

### tb/sv/tb_quoted_string_unescape.sv
// self-checking testbench for the quoted string unescaper
module tb_quoted_string_unescape;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5c;
  localparam logic [7:0] ESC_LETTERS [8] = '{"b", "t", "n", "f", "r", QUOTE, "/", BSLASH};

  // code point ranges that give 1..6 utf-8 bytes
  localparam logic [31:0] CLASS_LO [6] = '{32'h0, 32'h80, 32'h800, 32'h1_0000,
                                           32'h20_0000, 32'h400_0000};
  localparam logic [31:0] CLASS_HI [6] = '{32'h7f, 32'h7ff, 32'hffff, 32'h1f_ffff,
                                           32'h3ff_ffff, 32'hffff_ffff};

  localparam int RANDOM_REQS  = 370;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;

  // {operation, byte}
  localparam logic [8:0] DIRECTED_REQS [25] = '{
    {qsu_pkg::OP_BYTE, QUOTE},              // empty string
    {qsu_pkg::OP_END, 8'hff},               // end of input with no bytes seen
    {qsu_pkg::OP_BYTE, 8'h00}, {qsu_pkg::OP_BYTE, 8'hff},
    {qsu_pkg::OP_BYTE, BSLASH}, {qsu_pkg::OP_BYTE, "t"},
    {qsu_pkg::OP_BYTE, BSLASH}, {qsu_pkg::OP_BYTE, "U"},  // top of the code space
    {qsu_pkg::OP_BYTE, "F"}, {qsu_pkg::OP_BYTE, "f"},
    {qsu_pkg::OP_BYTE, "F"}, {qsu_pkg::OP_BYTE, "F"},
    {qsu_pkg::OP_BYTE, "F"}, {qsu_pkg::OP_BYTE, "F"},
    {qsu_pkg::OP_BYTE, "F"}, {qsu_pkg::OP_BYTE, "F"},
    {qsu_pkg::OP_BYTE, BSLASH}, {qsu_pkg::OP_BYTE, "u"},
    {qsu_pkg::OP_BYTE, "0"}, {qsu_pkg::OP_BYTE, "z"},
    {qsu_pkg::OP_BYTE, BSLASH}, {qsu_pkg::OP_BYTE, "q"},
    {qsu_pkg::OP_BYTE, "a"}, {qsu_pkg::OP_BYTE, BSLASH},
    {qsu_pkg::OP_END, 8'h00}                // end inside an escape
  };

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [15:0] pos;
    logic        last;
  } result_t;

  class unescape_scoreboard;
    logic [1:0]  mode;
    logic [31:0] code_acc;
    logic [3:0]  digits_left;
    logic [2:0]  digit_idx;
    logic [15:0] offset;
    result_t     due_results[$];
    int          errors;

    function new();
      start_string();
      errors = 0;
    endfunction

    function void start_string();
      mode        = qsu_pkg::MODE_TEXT;
      code_acc    = '0;
      digits_left = '0;
      digit_idx   = '0;
      offset      = '0;
    endfunction

    function void push(logic [7:0] b, logic [2:0] st, logic [15:0] pos);
      result_t r;
      r.out_byte = b;
      r.status   = st;
      r.pos      = pos;
      r.last     = 1'b0;
      due_results.push_back(r);
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void push_utf8(logic [31:0] v, logic [15:0] pos);
      int          n;
      logic [7:0]  lead;
      logic [31:0] sh;
      if (v < 32'h80) begin
        n = 1; lead = v[7:0];
      end else if (v < 32'h800) begin
        n = 2; lead = 8'hc0 | 8'(v >> 6);
      end else if (v < 32'h1_0000) begin
        n = 3; lead = 8'he0 | 8'(v >> 12);
      end else if (v < 32'h20_0000) begin
        n = 4; lead = 8'hf0 | 8'(v >> 18);
      end else if (v < 32'h400_0000) begin
        n = 5; lead = 8'hf8 | 8'(v >> 24);
      end else begin
        n = 6; lead = 8'hfc | 8'(v >> 30);
      end
      push(lead, qsu_pkg::ST_DATA, pos);
      for (int k = 1; k < n; k++) begin
        sh = v >> (6 * (n - 1 - k));
        push({2'b10, sh[5:0]}, qsu_pkg::ST_DATA, pos);
      end
    endfunction

    function void take_request(logic op, logic [7:0] c);
      int          first;
      int          h;
      logic [15:0] here;
      logic [15:0] nxt;
      logic [7:0]  mapped;
      first = due_results.size();
      here  = offset;
      nxt   = offset + 16'd1;
      if (op == qsu_pkg::OP_END) begin
        push(8'h00, qsu_pkg::ST_UNTERM, here);
        start_string();
      end else if (mode == qsu_pkg::MODE_ESC) begin
        mapped = 8'h00;
        case (c)
          "b":    mapped = 8'h08;
          "t":    mapped = 8'h09;
          "n":    mapped = 8'h0a;
          "f":    mapped = 8'h0c;
          "r":    mapped = 8'h0d;
          QUOTE:  mapped = QUOTE;
          "/":    mapped = 8'h2f;
          BSLASH: mapped = BSLASH;
          default: mapped = 8'h00;
        endcase
        if (c == "u" || c == "U") begin
          digits_left = (c == "u") ? 4'd4 : 4'd8;
          mode        = qsu_pkg::MODE_HEX;
          code_acc    = '0;
          digit_idx   = '0;
          offset      = nxt;
        end else if (mapped == 8'h00) begin
          // bad letter is reported at the backslash
          push(8'h00, qsu_pkg::ST_BADESC, here - 16'd1);
          start_string();
        end else begin
          push(mapped, qsu_pkg::ST_DATA, here);
          mode   = qsu_pkg::MODE_TEXT;
          offset = nxt;
        end
      end else if (mode == qsu_pkg::MODE_HEX) begin
        h = hex_val(c);
        if (h < 0) begin
          push(8'h00, qsu_pkg::ST_BADHEX, {13'd0, digit_idx});
          start_string();
        end else begin
          code_acc    = (code_acc << 4) | 32'(h);
          digit_idx   = digit_idx + 3'd1;
          digits_left = digits_left - 4'd1;
          if (digits_left == 4'd0) begin
            push_utf8(code_acc, here);
            mode      = qsu_pkg::MODE_TEXT;
            code_acc  = '0;
            digit_idx = '0;
          end
          offset = nxt;
        end
      end else if (c == QUOTE) begin
        push(8'h00, qsu_pkg::ST_OK, nxt);
        start_string();
      end else if (c == BSLASH) begin
        mode   = qsu_pkg::MODE_ESC;
        offset = nxt;
      end else begin
        push(c, qsu_pkg::ST_DATA, here);
        offset = nxt;
      end
      if (due_results.size() > first) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [23:0] data, logic [2:0] user, logic last);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing due: tdata=%h tuser=%h tlast=%b",
                         data, user, last));
        return;
      end
      want = due_results.pop_front();
      if (data[7:0] !== want.out_byte)
        report($sformatf("out_byte %h, want %h", data[7:0], want.out_byte));
      if (user !== want.status)
        report($sformatf("status %0d, want %0d", user, want.status));
      if (data[23:8] !== want.pos)
        report($sformatf("position %0d, want %0d", data[23:8], want.pos));
      if (last !== want.last)
        report($sformatf("tlast %b, want %b", last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  unescape_scoreboard sb = new();

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_kick      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int sent_reqs      = 0;
  int stuck          = 0;

  quoted_string_unescape dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when kicked
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if (s_tvalid && s_tready) sb.take_request(s_tuser, s_tdata);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck == STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_req(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_reqs++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == QUOTE || b == BSLASH);
    return b;
  endfunction

  // \u or \U escape; bad_at >= 0 puts a non-hex byte at that digit
  task automatic send_hex_escape(input bit wide, input int bad_at);
    int          ndig;
    int          cls;
    int          sel;
    logic [31:0] v;
    logic [3:0]  d;
    logic [7:0]  c;
    ndig = wide ? 8 : 4;
    cls  = $urandom_range(0, wide ? 5 : 2);
    sel  = $urandom_range(0, 3);
    if (sel == 0) v = CLASS_LO[cls];
    else if (sel == 1) v = CLASS_HI[cls];
    else v = $urandom_range(CLASS_HI[cls], CLASS_LO[cls]);
    send_req(qsu_pkg::OP_BYTE, BSLASH);
    send_req(qsu_pkg::OP_BYTE, wide ? "U" : "u");
    for (int k = 0; k < ndig; k++) begin
      if (k == bad_at) begin
        do c = 8'($urandom_range(0, 255));
        while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
        send_req(qsu_pkg::OP_BYTE, c);
        return;
      end
      d = v[4*(ndig-1-k) +: 4];
      if (d < 4'd10) c = "0" + {4'd0, d};
      else c = ($urandom_range(0, 1) ? "A" : "a") + {4'd0, d} - 8'd10;
      send_req(qsu_pkg::OP_BYTE, c);
    end
  endtask

  // one string with random content, mostly closed by a quote
  task automatic send_string();
    int         nseg;
    int         pick;
    logic [7:0] c;
    nseg = $urandom_range(1, 10);
    for (int i = 0; i < nseg; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_req(qsu_pkg::OP_BYTE, plain_byte());
      end else if (pick < 60) begin
        send_req(qsu_pkg::OP_BYTE, BSLASH);
        send_req(qsu_pkg::OP_BYTE, ESC_LETTERS[$urandom_range(0, 7)]);
      end else if (pick < 75) begin
        send_hex_escape(1'b0, -1);
      end else if (pick < 90) begin
        send_hex_escape(1'b1, -1);
      end else if (pick < 94) begin
        do c = 8'($urandom_range(0, 255));
        while (c inside {"b", "t", "n", "f", "r", "u", "U", QUOTE, "/", BSLASH});
        send_req(qsu_pkg::OP_BYTE, BSLASH);
        send_req(qsu_pkg::OP_BYTE, c);
        return;
      end else if (pick < 97) begin
        pick = $urandom_range(0, 1);
        send_hex_escape(pick[0], $urandom_range(0, pick ? 7 : 3));
        return;
      end else begin
        send_req(qsu_pkg::OP_END, 8'($urandom_range(0, 255)));
        return;
      end
    end
    send_req(qsu_pkg::OP_BYTE, QUOTE);
  endtask

  initial begin
    int goal;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_REQS[i]) send_req(DIRECTED_REQS[i][8], DIRECTED_REQS[i][7:0]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          // long receiver hold-off while requests keep coming
          hold_kick <= hold_kick + 1;
        end
        1: begin
          src_idle_pct   = 84;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 84;
        end
        default: begin
          src_idle_pct   = 28;
          sink_stall_pct = 28;
        end
      endcase
      goal = sent_reqs + RANDOM_REQS / 4;
      while (sent_reqs < goal) begin
        if ($urandom_range(0, 99) < 85) begin
          send_string();
        end else begin
          repeat ($urandom_range(1, 6))
            send_req(($urandom_range(0, 9) == 0) ? qsu_pkg::OP_END : qsu_pkg::OP_BYTE,
                     8'($urandom_range(0, 255)));
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
